/* design/swe_pkg.sv */
package swe_pkg;

   // Default sizes of the on-chip stores.
   localparam int DEF_MAX_POINTS   = 1024;
   localparam int DEF_MAX_CLUSTERS = 16;

   // Fixed widths of the transaction fields and registers.
   localparam int KIND_W         = 2;
   localparam int POINT_W        = 10;
   localparam int LABEL_W        = 4;
   localparam int DIST_W         = 32;
   localparam int NB_W           = 5;
   localparam int WIDTH_W        = 16;
   localparam int TOTAL_W        = 42;
   localparam int CSR_IDX_W      = 2;
   localparam int CSR_DATA_W     = 11;
   localparam int NUM_POINTS_W   = 11;
   localparam int NUM_CLUSTERS_W = 5;

   localparam logic [NUM_POINTS_W-1:0]   RST_NUM_POINTS   = 11'd2;
   localparam logic [NUM_CLUSTERS_W-1:0] RST_NUM_CLUSTERS = 5'd2;

   // The width is 16384 * ratio: fifteen quotient bits, then round half up.
   localparam int DIV_STEPS = 15;
   localparam int STEP_W    = 4;
   localparam int MAG_W     = 15;

   typedef enum logic [KIND_W-1:0] {
      KIND_CLEAR = 2'd0,
      KIND_LABEL = 2'd1,
      KIND_DIST  = 2'd2,
      KIND_QUERY = 2'd3
   } swe_kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_NUM_POINTS   = 2'd0,
      REG_NUM_CLUSTERS = 2'd1
   } swe_reg_type;

   typedef enum logic [4:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_DISPATCH,
      ST_L_RDLBL,
      ST_L_CHK,
      ST_L_RDOLD,
      ST_L_DEC,
      ST_L_RDNEW,
      ST_L_INC,
      ST_D_RDLQ,
      ST_D_RDLP,
      ST_D_RDT1,
      ST_D_WRT1,
      ST_D_WRT2,
      ST_Q_RDLBL,
      ST_Q_OWN,
      ST_Q_OWNRD,
      ST_Q_OWNCAP,
      ST_Q_WRD,
      ST_Q_WMUL,
      ST_Q_WCMP,
      ST_Q_FIN,
      ST_Q_SUB,
      ST_Q_DIV,
      ST_Q_RND,
      ST_Q_OUT
   } swe_state_type;

   typedef struct packed {
      logic load;
      logic sweep_step;
      logic lbl_rd_p;
      logic lbl_rd_q;
      logic lbl_wr;
      logic save_a;
      logic save_b;
      logic cnt_rd_a;
      logic cnt_rd_lab;
      logic cnt_dec;
      logic cnt_inc;
      logic tot_rd_pa;
      logic tot_rd_qb;
      logic tot_wr_pa;
      logic tot_wr_qb;
      logic q_init;
      logic own_cap;
      logic walk_rd;
      logic walk_mul;
      logic walk_cmp;
      logic fin_mul;
      logic sub;
      logic div_step;
      logic rnd;
      logic out_load;
   } swe_cmd_type;

   typedef struct packed {
      swe_kind_type kind;
      logic         lbl_ok;
      logic         dist_ok;
      logic         p_ok;
      logic         old_valid;
      logic         sweep_last;
      logic         walk_done;
      logic         fin_ok;
      logic         xy_eq;
      logic         div_last;
      logic         out_free;
   } swe_status_type;

endpackage

/* design/silhouette_width_engine_top.sv */
// One transaction is in work at a time: a label (with less to do for a point without a
// label, and less still when ignored), a distance (less when ignored), a clear that sweeps
// the stores, and a query, its result loading as it ends, plus any output stall. The single
// read port of the total store, the cluster walk and the 15-step divider set how long each
// takes. Reset is synchronous, active high; after it the stores are swept clear with
// req_stall high.
module silhouette_width_engine_top #(
   parameter int MAX_POINTS   = swe_pkg::DEF_MAX_POINTS,
   parameter int MAX_CLUSTERS = swe_pkg::DEF_MAX_CLUSTERS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [swe_pkg::KIND_W-1:0]         req_kind,
   input  logic [swe_pkg::POINT_W-1:0]        req_first_point,
   input  logic [swe_pkg::POINT_W-1:0]        req_second_point,
   input  logic [swe_pkg::LABEL_W-1:0]        req_cluster_label,
   input  logic [swe_pkg::DIST_W-1:0]         req_distance,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [swe_pkg::POINT_W-1:0]        rsp_point,
   output logic [swe_pkg::NB_W-1:0]           rsp_neighbor_cluster,
   output logic signed [swe_pkg::WIDTH_W-1:0] rsp_width,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [swe_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [swe_pkg::CSR_DATA_W-1:0]     csr_data
);
   import swe_pkg::*;

   swe_cmd_type    cmd;
   swe_status_type st;

   swe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .st        (st),
      .cmd       (cmd)
   );

   swe_datapath #(
      .MAX_POINTS   (MAX_POINTS),
      .MAX_CLUSTERS (MAX_CLUSTERS)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .st                   (st),
      .req_kind             (req_kind),
      .req_first_point      (req_first_point),
      .req_second_point     (req_second_point),
      .req_cluster_label    (req_cluster_label),
      .req_distance         (req_distance),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_point            (rsp_point),
      .rsp_neighbor_cluster (rsp_neighbor_cluster),
      .rsp_width            (rsp_width),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

endmodule

/* design/swe_ctrl.sv */
module swe_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  swe_pkg::swe_status_type st,
   output swe_pkg::swe_cmd_type    cmd
);
   import swe_pkg::*;

   swe_state_type state_ff;
   swe_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SWEEP;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_SWEEP: begin
            cmd.sweep_step = 1'b1;
            if (st.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            cmd.q_init = 1'b1;
            case (st.kind)
               KIND_CLEAR: state_in = ST_SWEEP;
               KIND_LABEL: state_in = st.lbl_ok ? ST_L_RDLBL : ST_IDLE;
               KIND_DIST:  state_in = st.dist_ok ? ST_D_RDLQ : ST_IDLE;
               KIND_QUERY: state_in = st.p_ok ? ST_Q_RDLBL : ST_Q_OUT;
               default:    state_in = ST_IDLE;
            endcase
         end
         ST_L_RDLBL: begin
            cmd.lbl_rd_p = 1'b1;
            state_in     = ST_L_CHK;
         end
         ST_L_CHK: begin
            cmd.save_a = 1'b1;
            state_in   = st.old_valid ? ST_L_RDOLD : ST_L_RDNEW;
         end
         ST_L_RDOLD: begin
            cmd.cnt_rd_a = 1'b1;
            state_in     = ST_L_DEC;
         end
         ST_L_DEC: begin
            cmd.cnt_dec = 1'b1;
            state_in    = ST_L_RDNEW;
         end
         ST_L_RDNEW: begin
            cmd.cnt_rd_lab = 1'b1;
            state_in       = ST_L_INC;
         end
         ST_L_INC: begin
            cmd.cnt_inc = 1'b1;
            cmd.lbl_wr  = 1'b1;
            state_in    = ST_IDLE;
         end
         ST_D_RDLQ: begin
            cmd.lbl_rd_q = 1'b1;
            state_in     = ST_D_RDLP;
         end
         ST_D_RDLP: begin
            cmd.lbl_rd_p = 1'b1;
            cmd.save_a   = 1'b1;
            state_in     = ST_D_RDT1;
         end
         ST_D_RDT1: begin
            cmd.save_b    = 1'b1;
            cmd.tot_rd_pa = 1'b1;
            state_in      = ST_D_WRT1;
         end
         ST_D_WRT1: begin
            cmd.tot_wr_pa = 1'b1;
            cmd.tot_rd_qb = 1'b1;
            state_in      = ST_D_WRT2;
         end
         ST_D_WRT2: begin
            cmd.tot_wr_qb = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_Q_RDLBL: begin
            cmd.lbl_rd_p = 1'b1;
            state_in     = ST_Q_OWN;
         end
         ST_Q_OWN: begin
            cmd.save_a = 1'b1;
            state_in   = ST_Q_OWNRD;
         end
         ST_Q_OWNRD: begin
            cmd.tot_rd_pa = 1'b1;
            cmd.cnt_rd_a  = 1'b1;
            state_in      = ST_Q_OWNCAP;
         end
         ST_Q_OWNCAP: begin
            cmd.own_cap = 1'b1;
            state_in    = ST_Q_WRD;
         end
         ST_Q_WRD: begin
            if (st.walk_done) begin
               state_in = ST_Q_FIN;
            end else begin
               cmd.walk_rd = 1'b1;
               state_in    = ST_Q_WMUL;
            end
         end
         ST_Q_WMUL: begin
            cmd.walk_mul = 1'b1;
            state_in     = ST_Q_WCMP;
         end
         ST_Q_WCMP: begin
            cmd.walk_cmp = 1'b1;
            state_in     = ST_Q_WRD;
         end
         ST_Q_FIN: begin
            if (st.fin_ok) begin
               cmd.fin_mul = 1'b1;
               state_in    = ST_Q_SUB;
            end else begin
               state_in = ST_Q_OUT;
            end
         end
         ST_Q_SUB: begin
            if (st.xy_eq) begin
               state_in = ST_Q_OUT;
            end else begin
               cmd.sub  = 1'b1;
               state_in = ST_Q_DIV;
            end
         end
         ST_Q_DIV: begin
            cmd.div_step = 1'b1;
            if (st.div_last) begin
               state_in = ST_Q_RND;
            end
         end
         ST_Q_RND: begin
            cmd.rnd  = 1'b1;
            state_in = ST_Q_OUT;
         end
         ST_Q_OUT: begin
            if (st.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_SWEEP;
      endcase
   end

endmodule

/* design/swe_datapath.sv */
module swe_datapath #(
   parameter int MAX_POINTS   = swe_pkg::DEF_MAX_POINTS,
   parameter int MAX_CLUSTERS = swe_pkg::DEF_MAX_CLUSTERS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  swe_pkg::swe_cmd_type                   cmd,
   output swe_pkg::swe_status_type                st,
   input  logic [swe_pkg::KIND_W-1:0]             req_kind,
   input  logic [swe_pkg::POINT_W-1:0]            req_first_point,
   input  logic [swe_pkg::POINT_W-1:0]            req_second_point,
   input  logic [swe_pkg::LABEL_W-1:0]            req_cluster_label,
   input  logic [swe_pkg::DIST_W-1:0]             req_distance,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [swe_pkg::POINT_W-1:0]            rsp_point,
   output logic [swe_pkg::NB_W-1:0]               rsp_neighbor_cluster,
   output logic signed [swe_pkg::WIDTH_W-1:0]     rsp_width,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [swe_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [swe_pkg::CSR_DATA_W-1:0]         csr_data
);
   import swe_pkg::*;

   localparam int PW     = $clog2(MAX_POINTS);
   localparam int CW     = $clog2(MAX_CLUSTERS);
   localparam int TW     = PW + CW;
   localparam int NW     = $clog2(MAX_POINTS + 1);
   localparam int PRODW  = TOTAL_W + NW;
   localparam int LDEPTH = 1 << PW;
   localparam int CDEPTH = 1 << CW;
   localparam int TDEPTH = 1 << TW;

   // Configuration registers.
   logic [NUM_POINTS_W-1:0]   num_points_ff;
   logic [NUM_CLUSTERS_W-1:0] num_clusters_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_points_ff   <= RST_NUM_POINTS;
         num_clusters_ff <= RST_NUM_CLUSTERS;
      end else if (csr_valid && csr_ready) begin
         case (swe_reg_type'(csr_index))
            REG_NUM_POINTS:   num_points_ff   <= csr_data;
            REG_NUM_CLUSTERS: num_clusters_ff <= NUM_CLUSTERS_W'(csr_data);
            default: ;
         endcase
      end
   end

   // Captured transaction.
   swe_kind_type        kind_ff;
   logic [POINT_W-1:0]  p_ff;
   logic [POINT_W-1:0]  q_ff;
   logic [LABEL_W-1:0]  lab_ff;
   logic [DIST_W-1:0]   dist_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= swe_kind_type'(req_kind);
         p_ff    <= req_first_point;
         q_ff    <= req_second_point;
         lab_ff  <= req_cluster_label;
         dist_ff <= req_distance;
      end
   end

   logic [PW-1:0] p_idx;
   logic [PW-1:0] q_idx;
   logic [CW-1:0] lab_idx;

   assign p_idx   = PW'(p_ff);
   assign q_idx   = PW'(q_ff);
   assign lab_idx = CW'(lab_ff);

   // Sweep counter walks every total entry; labels and counts are cleared on the way.
   logic [TW-1:0] sweep_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= '0;
      end else if (cmd.sweep_step) begin
         sweep_ff <= sweep_ff + 1'b1;
      end
   end

   // Label store: a valid bit above the label.
   logic [CW:0]   lbl_mem [LDEPTH];
   logic [CW:0]   lbl_rd_ff;
   logic          lbl_we;
   logic [PW-1:0] lbl_waddr;
   logic [CW:0]   lbl_wdata;
   logic [PW-1:0] lbl_raddr;
   logic [CW-1:0] lbl_of_rd;

   always_comb begin
      lbl_we    = 1'b0;
      lbl_waddr = p_idx;
      lbl_wdata = {1'b1, lab_idx};
      if (cmd.sweep_step) begin
         lbl_we    = (sweep_ff[CW-1:0] == '0);
         lbl_waddr = sweep_ff[TW-1:CW];
         lbl_wdata = '0;
      end else if (cmd.lbl_wr) begin
         lbl_we = 1'b1;
      end
   end

   assign lbl_raddr = cmd.lbl_rd_q ? q_idx : p_idx;
   assign lbl_of_rd = lbl_rd_ff[CW] ? lbl_rd_ff[CW-1:0] : '0;

   always_ff @(posedge clock) begin
      if (lbl_we) begin
         lbl_mem[lbl_waddr] <= lbl_wdata;
      end
      if (cmd.lbl_rd_p || cmd.lbl_rd_q) begin
         lbl_rd_ff <= lbl_mem[lbl_raddr];
      end
   end

   logic [CW-1:0] lab_a_ff;
   logic [CW-1:0] lab_b_ff;

   always_ff @(posedge clock) begin
      if (cmd.save_a) begin
         lab_a_ff <= lbl_of_rd;
      end
      if (cmd.save_b) begin
         lab_b_ff <= lbl_of_rd;
      end
   end

   // Walk counter over clusters.
   logic [CW:0] c_ff;

   // Cluster size store.
   logic [NW-1:0] cnt_mem [CDEPTH];
   logic [NW-1:0] cnt_rd_ff;
   logic          cnt_we;
   logic [CW-1:0] cnt_waddr;
   logic [NW-1:0] cnt_wdata;
   logic [CW-1:0] cnt_raddr;

   always_comb begin
      cnt_we    = 1'b0;
      cnt_waddr = lab_a_ff;
      cnt_wdata = cnt_rd_ff - 1'b1;
      if (cmd.sweep_step) begin
         cnt_we    = (sweep_ff[TW-1:CW] == '0);
         cnt_waddr = sweep_ff[CW-1:0];
         cnt_wdata = '0;
      end else if (cmd.cnt_dec) begin
         cnt_we = (cnt_rd_ff != '0);
      end else if (cmd.cnt_inc) begin
         cnt_we    = 1'b1;
         cnt_waddr = lab_idx;
         cnt_wdata = cnt_rd_ff + 1'b1;
      end
   end

   always_comb begin
      cnt_raddr = lab_a_ff;
      if (cmd.cnt_rd_lab) begin
         cnt_raddr = lab_idx;
      end else if (cmd.walk_rd) begin
         cnt_raddr = c_ff[CW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_waddr] <= cnt_wdata;
      end
      if (cmd.cnt_rd_a || cmd.cnt_rd_lab || cmd.walk_rd) begin
         cnt_rd_ff <= cnt_mem[cnt_raddr];
      end
   end

   // Distance total store, addressed by point and cluster.
   logic [TOTAL_W-1:0] tot_mem [TDEPTH];
   logic [TOTAL_W-1:0] tot_rd_ff;
   logic               tot_we;
   logic [TW-1:0]      tot_waddr;
   logic [TOTAL_W-1:0] tot_wdata;
   logic [TW-1:0]      tot_raddr;
   logic [TOTAL_W:0]   tot_sum_in;

   assign tot_sum_in = {1'b0, tot_rd_ff} + (TOTAL_W + 1)'(dist_ff);

   always_comb begin
      tot_we    = 1'b0;
      tot_waddr = {p_idx, lab_a_ff};
      tot_wdata = tot_sum_in[TOTAL_W] ? '1 : tot_sum_in[TOTAL_W-1:0];
      if (cmd.sweep_step) begin
         tot_we    = 1'b1;
         tot_waddr = sweep_ff;
         tot_wdata = '0;
      end else if (cmd.tot_wr_pa) begin
         tot_we = 1'b1;
      end else if (cmd.tot_wr_qb) begin
         tot_we    = 1'b1;
         tot_waddr = {q_idx, lab_b_ff};
      end
   end

   always_comb begin
      tot_raddr = {p_idx, lab_a_ff};
      if (cmd.tot_rd_qb) begin
         tot_raddr = {q_idx, lab_b_ff};
      end else if (cmd.walk_rd) begin
         tot_raddr = {p_idx, c_ff[CW-1:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (tot_we) begin
         tot_mem[tot_waddr] <= tot_wdata;
      end
      if (cmd.tot_rd_pa || cmd.tot_rd_qb || cmd.walk_rd) begin
         tot_rd_ff <= tot_mem[tot_raddr];
      end
   end

   // Query: neighbor search by cross products, then the ratio divider.
   logic                 found_ff;
   logic [CW:0]          nb_ff;
   logic [TOTAL_W-1:0]   bt_ff;
   logic [NW-1:0]        bn_ff;
   logic [TOTAL_W-1:0]   ta_ff;
   logic [NW-1:0]        na_ff;
   logic [TOTAL_W-1:0]   cand_t_ff;
   logic [NW-1:0]        cand_n_ff;
   logic                 skip_ff;
   logic [PRODW-1:0]     m1_ff;
   logic [PRODW-1:0]     m2_ff;
   logic [PRODW-1:0]     x_ff;
   logic [PRODW-1:0]     y_ff;
   logic [PRODW-1:0]     r_ff;
   logic [PRODW-1:0]     d_ff;
   logic [DIV_STEPS-1:0] qt_ff;
   logic [STEP_W-1:0]    step_ff;
   logic                 neg_ff;
   logic [MAG_W-1:0]     mag_ff;
   logic [PRODW:0]       r_sh;
   logic [PRODW:0]       r_diff;
   logic [MAG_W:0]       q_rnd;

   assign r_sh   = {r_ff, 1'b0};
   assign r_diff = r_sh - {1'b0, d_ff};
   assign q_rnd  = {1'b0, qt_ff} + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (cmd.q_init) begin
         found_ff <= 1'b0;
      end else if (cmd.walk_cmp && !skip_ff && (!found_ff || m1_ff < m2_ff)) begin
         found_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.q_init) begin
         nb_ff  <= '0;
         mag_ff <= '0;
         neg_ff <= 1'b0;
      end
      if (cmd.own_cap) begin
         ta_ff <= tot_rd_ff;
         na_ff <= cnt_rd_ff;
         c_ff  <= '0;
      end
      if (cmd.walk_mul) begin
         cand_t_ff <= tot_rd_ff;
         cand_n_ff <= cnt_rd_ff;
         m1_ff     <= PRODW'(tot_rd_ff) * PRODW'(bn_ff);
         m2_ff     <= PRODW'(bt_ff) * PRODW'(cnt_rd_ff);
         skip_ff   <= (c_ff == {1'b0, lab_a_ff}) || (cnt_rd_ff == '0);
      end
      if (cmd.walk_cmp) begin
         if (!skip_ff && (!found_ff || m1_ff < m2_ff)) begin
            bt_ff <= cand_t_ff;
            bn_ff <= cand_n_ff;
            nb_ff <= c_ff + 1'b1;
         end
         c_ff <= c_ff + 1'b1;
      end
      if (cmd.fin_mul) begin
         x_ff <= PRODW'(ta_ff) * PRODW'(bn_ff);
         y_ff <= PRODW'(bt_ff) * PRODW'(na_ff - 1'b1);
      end
      if (cmd.sub) begin
         if (x_ff < y_ff) begin
            r_ff   <= y_ff - x_ff;
            d_ff   <= y_ff;
            neg_ff <= 1'b0;
         end else begin
            r_ff   <= x_ff - y_ff;
            d_ff   <= x_ff;
            neg_ff <= 1'b1;
         end
         qt_ff   <= '0;
         step_ff <= '0;
      end
      if (cmd.div_step) begin
         // The remainder never exceeds the divisor, so it always fits back.
         if (r_sh >= {1'b0, d_ff}) begin
            r_ff  <= r_diff[PRODW-1:0];
            qt_ff <= {qt_ff[DIV_STEPS-2:0], 1'b1};
         end else begin
            r_ff  <= r_sh[PRODW-1:0];
            qt_ff <= {qt_ff[DIV_STEPS-2:0], 1'b0};
         end
         step_ff <= step_ff + 1'b1;
      end
      if (cmd.rnd) begin
         mag_ff <= q_rnd[MAG_W:1];
      end
   end

   // Output register.
   logic                      rsp_valid_ff;
   logic [POINT_W-1:0]        rsp_point_ff;
   logic [NB_W-1:0]           rsp_nb_ff;
   logic signed [WIDTH_W-1:0] rsp_width_ff;
   logic [WIDTH_W-1:0]        mag_ext;

   assign mag_ext = WIDTH_W'(mag_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_point_ff <= p_ff;
         rsp_nb_ff    <= NB_W'(nb_ff);
         rsp_width_ff <= neg_ff ? $signed(-mag_ext) : $signed(mag_ext);
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_point            = rsp_point_ff;
   assign rsp_neighbor_cluster = rsp_nb_ff;
   assign rsp_width            = rsp_width_ff;

   // Status toward the controller.
   logic p_in_range;
   logic q_in_range;

   assign p_in_range = (32'(p_ff) < 32'(num_points_ff)) && (32'(p_ff) < 32'(MAX_POINTS));
   assign q_in_range = (32'(q_ff) < 32'(num_points_ff)) && (32'(q_ff) < 32'(MAX_POINTS));

   always_comb begin
      st.kind       = kind_ff;
      st.p_ok       = p_in_range;
      st.lbl_ok     = p_in_range && (32'(lab_ff) < 32'(num_clusters_ff))
                      && (32'(lab_ff) < 32'(MAX_CLUSTERS));
      st.dist_ok    = p_in_range && q_in_range && (p_ff != q_ff);
      st.old_valid  = lbl_rd_ff[CW];
      st.sweep_last = (sweep_ff == '1);
      st.walk_done  = (32'(c_ff) >= 32'(num_clusters_ff))
                      || (32'(c_ff) >= 32'(MAX_CLUSTERS));
      st.fin_ok     = found_ff && (32'(na_ff) >= 32'd2);
      st.xy_eq      = (x_ff == y_ff);
      st.div_last   = (32'(step_ff) == DIV_STEPS - 1);
      st.out_free   = !rsp_valid_ff || !rsp_stall;
   end

endmodule

/* design/swe_checker.sv */
module swe_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_stall,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic [swe_pkg::POINT_W-1:0]        rsp_point,
   input logic [swe_pkg::NB_W-1:0]           rsp_neighbor_cluster,
   input logic signed [swe_pkg::WIDTH_W-1:0] rsp_width
);

   // A result waiting on a stalled consumer must hold.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_point)
         && $stable(rsp_neighbor_cluster) && $stable(rsp_width))
      else $error("result changed while stalled");

   a_width_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_width >= -16'sd16384) && (rsp_width <= 16'sd16384))
      else $error("silhouette width out of range");

   // Without a neighbor cluster there is no width to report.
   a_no_neighbor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_neighbor_cluster == '0) |-> (rsp_width == '0))
      else $error("nonzero width without a neighbor cluster");

   // The clearing sweep after reset holds off the request side.
   a_reset_stall: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("request taken right after reset");

endmodule

bind silhouette_width_engine_top swe_checker u_swe_checker (.*);
